/* hdl/tcpq_pkg.sv */
// Package for the three-class priority queue.
// Holds the action and status codes, class codes, field widths and the
// per-item decision record. Depends on nothing.
`default_nettype none

package tcpq_pkg;

	localparam int VAL_W   = 32;
	localparam int CODE_W  = 8;
	localparam int CNT_W   = 6;
	localparam int CLS_W   = 2;
	localparam int ACT_W   = 2;
	localparam int STAT_W  = 2;

	// Character codes that select the two upper classes.
	localparam logic [CODE_W-1:0] CODE_FIRST  = 8'h56;
	localparam logic [CODE_W-1:0] CODE_SECOND = 8'h43;

	localparam logic [CLS_W-1:0] CLS_FIRST  = 2'd0;
	localparam logic [CLS_W-1:0] CLS_SECOND = 2'd1;
	localparam logic [CLS_W-1:0] CLS_THIRD  = 2'd2;

	typedef enum logic [ACT_W-1:0] {
		ACT_ENQ      = 2'd0,
		ACT_POP_HEAD = 2'd1,
		ACT_POP_TAIL = 2'd2,
		ACT_CLEAR    = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Outcome of one item, decided from the class pointers at accept time.
	typedef struct packed {
		status_t           status;
		logic [CLS_W-1:0]  rm_class;
		logic              rd_en;
		logic              wr_en;
		logic [CNT_W-1:0]  total_count;
		logic              is_empty;
	} tcpq_dec_t;

endpackage

`default_nettype wire

/* hdl/tcpq_ifs.sv */
// Handshake channels of the three-class priority queue: request and response.
// Each carries valid, ready and the item payload. Depends on tcpq_pkg.
`default_nettype none

interface tcpq_req_if import tcpq_pkg::*; ;
	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic signed [VAL_W-1:0]  value;
	logic [CODE_W-1:0]        priority_code;

	modport source (output valid, action, value, priority_code, input ready);
	modport sink   (input valid, action, value, priority_code, output ready);
endinterface

interface tcpq_rsp_if import tcpq_pkg::*; ;
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [VAL_W-1:0]  removed_value;
	logic [CLS_W-1:0]         removed_class;
	logic [CNT_W-1:0]         total_count;
	logic                     is_empty;

	modport source (output valid, status, removed_value, removed_class, total_count,
		is_empty, input ready);
	modport sink   (input valid, status, removed_value, removed_class, total_count,
		is_empty, output ready);
endinterface

`default_nettype wire

/* hdl/three_class_priority_queue.sv */
// Top level of the three-class strict priority queue: entry-store memory,
// read stage and output register. Depends on tcpq_pkg, tcpq_ifs, tcpq_cls_state.
//
//   port  direction  fields
//   req   sink       action, value, priority_code
//   rsp   source     status, removed_value, removed_class, total_count, is_empty
//
// Each item's entry-store read lands in the read stage and its result in the output
// register; a new item can be accepted every cycle unless the response stalls.
// Class pointers update at accept, so a later item always sees earlier ones.
// Reset clears the class pointers and the pipeline; the entry store is not cleared.
// A stalled response holds the read stage, and req.ready drops once both are full.
`default_nettype none

module three_class_priority_queue import tcpq_pkg::*; #(
	parameter int CLASS_DEPTH = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tcpq_req_if.sink     req,
	tcpq_rsp_if.source   rsp
);

	localparam int AW    = $clog2(3 * CLASS_DEPTH);
	localparam int DEPTH = 3 * CLASS_DEPTH;

	logic                     acc;
	logic                     s1_move;
	tcpq_dec_t                dec;
	logic [AW-1:0]            slot;

	logic [VAL_W-1:0]         mem_q [DEPTH];
	logic [VAL_W-1:0]         rd_data_s1;
	logic                     valid_s1;
	tcpq_dec_t                dec_s1;

	logic                     out_valid_q;
	logic [STAT_W-1:0]        status_q;
	logic signed [VAL_W-1:0]  removed_value_q;
	logic [CLS_W-1:0]         removed_class_q;
	logic [CNT_W-1:0]         total_count_q;
	logic                     is_empty_q;

	assign s1_move   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || s1_move;
	assign acc       = req.valid && req.ready;

	tcpq_cls_state #(
		.CLASS_DEPTH (CLASS_DEPTH)
	) u_cls (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (acc),
		.action        (req.action),
		.priority_code (req.priority_code),
		.dec           (dec),
		.slot          (slot)
	);

	// Read data is only loaded by a removal, so a stalled stage keeps its word.
	always_ff @(posedge clk) begin
		if (acc && dec.wr_en) begin
			mem_q[slot] <= req.value;
		end
		if (acc && dec.rd_en) begin
			rd_data_s1 <= mem_q[slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			dec_s1 <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			status_q        <= dec_s1.status;
			removed_value_q <= dec_s1.rd_en ? rd_data_s1 : '0;
			removed_class_q <= dec_s1.rm_class;
			total_count_q   <= dec_s1.total_count;
			is_empty_q      <= dec_s1.is_empty;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.removed_value = removed_value_q;
	assign rsp.removed_class = removed_class_q;
	assign rsp.total_count   = total_count_q;
	assign rsp.is_empty      = is_empty_q;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_move |-> !acc)
		else $error("item accepted over a stalled read stage");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> out_valid_q)
		else $error("read stage moved without loading the output");

	a_no_rw_same: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> !(dec.rd_en && dec.wr_en))
		else $error("item both reads and writes the entry store");

endmodule

`default_nettype wire

/* hdl/tcpq_cls_state.sv */
// Per-class head and fill registers of the priority queue, with the logic
// that decides each item's outcome and entry-store slot. Depends on tcpq_pkg.
`default_nettype none

module tcpq_cls_state import tcpq_pkg::*; #(
	parameter int CLASS_DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  take,
	input  wire logic [ACT_W-1:0]                      action,
	input  wire logic [CODE_W-1:0]                     priority_code,
	output tcpq_dec_t                                  dec,
	output logic [$clog2(3*CLASS_DEPTH)-1:0]           slot
);

	localparam int PW    = $clog2(CLASS_DEPTH);
	localparam int FW    = $clog2(CLASS_DEPTH + 1);
	localparam int AW    = $clog2(3 * CLASS_DEPTH);
	localparam int SUM_W = FW + 2;
	localparam logic [FW-1:0] FILL_MAX  = FW'(CLASS_DEPTH);
	localparam logic [PW:0]   DEPTH_EXT = (PW + 1)'(CLASS_DEPTH);
	localparam logic [PW-1:0] HEAD_LAST = PW'(CLASS_DEPTH - 1);

	logic [PW-1:0]       head_q [3];
	logic [FW-1:0]       fill_q [3];
	logic [PW-1:0]       head_d [3];
	logic [FW-1:0]       fill_d [3];

	logic [CLS_W-1:0]    enq_cls;
	logic [CLS_W-1:0]    hd_cls;
	logic [CLS_W-1:0]    tl_cls;
	logic [CLS_W-1:0]    sel;
	logic                any_held;
	logic [PW-1:0]       off;
	logic [PW:0]         pos_sum;
	logic [PW-1:0]       pos;
	logic [FW-1:0]       fill_less;
	logic [SUM_W-1:0]    next_sum;
	logic [SUM_W-1:0]    cur_sum;
	logic [CNT_W+SUM_W-1:0] sum_pad;

	always_comb begin
		if (priority_code == CODE_FIRST) begin
			enq_cls = CLS_FIRST;
		end else if (priority_code == CODE_SECOND) begin
			enq_cls = CLS_SECOND;
		end else begin
			enq_cls = CLS_THIRD;
		end
	end

	assign any_held = (fill_q[0] != '0) || (fill_q[1] != '0) || (fill_q[2] != '0);
	assign hd_cls = (fill_q[0] != '0) ? CLS_FIRST :
		(fill_q[1] != '0) ? CLS_SECOND : CLS_THIRD;
	assign tl_cls = (fill_q[2] != '0) ? CLS_THIRD :
		(fill_q[1] != '0) ? CLS_SECOND : CLS_FIRST;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			head_d[k] = head_q[k];
			fill_d[k] = fill_q[k];
		end
		sel          = CLS_FIRST;
		off          = '0;
		dec.status   = ST_OK;
		dec.rm_class = CLS_FIRST;
		dec.rd_en    = 1'b0;
		dec.wr_en    = 1'b0;
		fill_less    = '0;
		case (action_t'(action))
			ACT_ENQ: begin
				sel = enq_cls;
				if (fill_q[sel] == FILL_MAX) begin
					dec.status = ST_FULL;
				end else begin
					dec.wr_en   = 1'b1;
					off         = fill_q[sel][PW-1:0];
					fill_d[sel] = fill_q[sel] + 1'b1;
				end
			end
			ACT_POP_HEAD: begin
				sel = hd_cls;
				if (!any_held) begin
					dec.status = ST_EMPTY;
				end else begin
					dec.rd_en    = 1'b1;
					dec.rm_class = sel;
					head_d[sel]  = (head_q[sel] == HEAD_LAST) ? '0 : head_q[sel] + 1'b1;
					fill_d[sel]  = fill_q[sel] - 1'b1;
				end
			end
			ACT_POP_TAIL: begin
				sel = tl_cls;
				if (!any_held) begin
					dec.status = ST_EMPTY;
				end else begin
					fill_less    = fill_q[sel] - 1'b1;
					dec.rd_en    = 1'b1;
					dec.rm_class = sel;
					off          = fill_less[PW-1:0];
					fill_d[sel]  = fill_less;
				end
			end
			ACT_CLEAR: begin
				for (int k = 0; k < 3; k++) begin
					head_d[k] = '0;
					fill_d[k] = '0;
				end
			end
			default: begin
				dec.status = ST_OK;
			end
		endcase
		next_sum = SUM_W'(fill_d[0]) + SUM_W'(fill_d[1]) + SUM_W'(fill_d[2]);
		sum_pad  = {{CNT_W{1'b0}}, next_sum};
		dec.total_count = sum_pad[CNT_W-1:0];
		dec.is_empty    = (next_sum == '0);
	end

	// Ring position within the class; head and offset are both below the depth.
	assign pos_sum = {1'b0, head_q[sel]} + {1'b0, off};
	assign pos = (pos_sum >= DEPTH_EXT) ? PW'(pos_sum - DEPTH_EXT) : pos_sum[PW-1:0];

	always_comb begin
		case (sel)
			CLS_FIRST:  slot = AW'(pos);
			CLS_SECOND: slot = AW'(pos) + AW'(CLASS_DEPTH);
			default:    slot = AW'(pos) + AW'(2 * CLASS_DEPTH);
		endcase
	end

	assign cur_sum  = SUM_W'(fill_q[0]) + SUM_W'(fill_q[1]) + SUM_W'(fill_q[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				head_q[k] <= '0;
				fill_q[k] <= '0;
			end
		end else if (take) begin
			for (int k = 0; k < 3; k++) begin
				head_q[k] <= head_d[k];
				fill_q[k] <= fill_d[k];
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q[0] <= FILL_MAX) && (fill_q[1] <= FILL_MAX) && (fill_q[2] <= FILL_MAX))
		else $error("class fill above depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		take && (action == ACT_CLEAR) |=> (cur_sum == '0))
		else $error("clear left entries behind");

	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		take && (action == ACT_ENQ) && (dec.status == ST_OK)
		|=> (cur_sum == $past(cur_sum) + 1'b1))
		else $error("accepted enqueue did not add one entry");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		take && dec.rd_en |=> (cur_sum == $past(cur_sum) - 1'b1))
		else $error("removal did not take one entry");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(cur_sum))
		else $error("fill changed without an item");

endmodule

`default_nettype wire
